// ===== sv/four_class_job_fifo_core_defines.svh =====
// Assertion macros for the four-class job FIFO core.
// Included by the top level only; the bodies drop out when SYNTH is defined.
`ifndef FOUR_CLASS_JOB_FIFO_CORE_DEFINES_SVH
`define FOUR_CLASS_JOB_FIFO_CORE_DEFINES_SVH
`ifndef SYNTH
`define FCJF_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FCJF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCJF_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define FCJF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/fcjf_pkg.sv =====
// Shared types and constants of the four-class job FIFO core.
// No dependencies.
package fcjf_pkg;

    localparam int NUM_QUEUES      = 4;
    localparam int QID_W           = 2;
    localparam int JOBNUM_W        = 16;
    localparam int JOB_IN_W        = 32;
    localparam int JOB_OUT_W       = 32;
    localparam int DEF_QUEUE_DEPTH = 256;
    localparam int DEF_JOB_ID_BITS = 32;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_POP = 1'b1;

    localparam logic [QID_W-1:0] Q_A = 2'd0;
    localparam logic [QID_W-1:0] Q_B = 2'd1;
    localparam logic [QID_W-1:0] Q_C = 2'd2;
    localparam logic [QID_W-1:0] Q_D = 2'd3;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DROP  = 2'd1,
        ST_POP   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        t_status             status;
        logic [QID_W-1:0]    qid;
        logic [JOBNUM_W-1:0] job_number;
    } t_cmd;

endpackage

// ===== sv/four_class_job_fifo_core.sv =====
// Four job queues A..D sharing one job store, with strict-priority pop.
// An enqueue result is registered directly; a pop waits in r_rd_pend, as the job id
// comes back from the registered read of the job store. The result sits in an
// output register, and the next item is taken in the same cycle that register
// is emptied. Pointers and counts live in flip-flops and are usable straight out
// of reset; the job store needs no clearing, as a slot is only read once written.
// Depends on fcjf_pkg, fcjf_ctrl, fcjf_ram and four_class_job_fifo_core_defines.svh.
`include "four_class_job_fifo_core_defines.svh"

module four_class_job_fifo_core
    import fcjf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int JOB_ID_BITS = DEF_JOB_ID_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic [QID_W-1:0]     i_queue_sel,
    input  logic [JOB_IN_W-1:0]  i_job_id,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [QID_W-1:0]     o_queue_id,
    output logic [JOBNUM_W-1:0]  o_job_number,
    output logic [JOB_OUT_W-1:0] o_job_out
);

    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    t_cmd                   w_cmd;
    logic [ADDR_W-1:0]      w_addr;
    logic                   w_fire;
    logic [63:0]            w_id_ext;
    logic [63:0]            w_rd_ext;
    logic [JOB_ID_BITS-1:0] w_rd_data;

    logic                  r_rd_pend;
    logic                  r_out_valid;
    t_status               r_status;
    logic [QID_W-1:0]      r_qid;
    logic [JOBNUM_W-1:0]   r_job_number;
    logic [JOB_OUT_W-1:0]  r_job_out;

    assign o_in_ready = !r_rd_pend && (!r_out_valid || i_out_ready);
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_id_ext   = 64'(i_job_id);
    assign w_rd_ext   = 64'(w_rd_data);

    fcjf_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_op        (i_op),
        .i_queue_sel (i_queue_sel),
        .o_cmd       (w_cmd),
        .o_addr      (w_addr)
    );

    fcjf_ram #(
        .WIDTH (JOB_ID_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_job_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_fire && w_cmd.wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_id_ext[JOB_ID_BITS-1:0]),
        .i_rd_en   (w_fire && w_cmd.rd_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (r_rd_pend) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b1;
            r_job_out   <= w_rd_ext[JOB_OUT_W-1:0];
        end else if (w_fire) begin
            r_rd_pend    <= w_cmd.rd_en;
            r_out_valid  <= !w_cmd.rd_en;
            r_status     <= w_cmd.status;
            r_qid        <= w_cmd.qid;
            r_job_number <= w_cmd.job_number;
            r_job_out    <= '0;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_queue_id   = r_qid;
    assign o_job_number = r_job_number;
    assign o_job_out    = r_job_out;

    `FCJF_ASSERT_NEXT(a_pop_read_pends, i_clk, i_rst_n, w_fire && w_cmd.rd_en, r_rd_pend && !o_out_valid, "pop transaction did not wait for the job store")
    `FCJF_ASSERT_NEXT(a_read_lands, i_clk, i_rst_n, r_rd_pend, o_out_valid && !r_rd_pend && (o_status == ST_POP), "job store read did not reach the output register")
    `FCJF_ASSERT_NEXT(a_direct_result, i_clk, i_rst_n, w_fire && !w_cmd.rd_en, o_out_valid && (o_job_out == '0), "enqueue or empty result missing")
    `FCJF_ASSERT_SAME(a_no_pop_fields, i_clk, i_rst_n, o_out_valid && (o_status != ST_POP), (o_job_number == '0) && (o_job_out == '0), "non-pop result carries job fields")

endmodule

// ===== sv/fcjf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fcjf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/fcjf_ctrl.sv =====
// Per-queue head, tail, occupancy and pop number; priority pick and memory address.
// Depends on fcjf_pkg.
module fcjf_ctrl
    import fcjf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ADDR_W      = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_op,
    input  logic [QID_W-1:0]  i_queue_sel,
    output t_cmd              o_cmd,
    output logic [ADDR_W-1:0] o_addr
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [PTR_W-1:0]    r_head [NUM_QUEUES];
    logic [PTR_W-1:0]    r_tail [NUM_QUEUES];
    logic [OCC_W-1:0]    r_occ  [NUM_QUEUES];
    logic [JOBNUM_W-1:0] r_pops [NUM_QUEUES];

    logic [NUM_QUEUES-1:0] w_nonempty;
    logic                  w_any;
    logic [QID_W-1:0]      w_pop_q;
    logic [QID_W-1:0]      w_q;
    logic                  w_full;
    logic [PTR_W-1:0]      w_ptr;
    logic [PTR_W-1:0]      w_ptr_next;
    logic [ADDR_W-1:0]     w_base;
    t_cmd                  w_cmd;

    always_comb begin
        for (int k = 0; k < NUM_QUEUES; k++) begin
            w_nonempty[k] = (r_occ[k] != '0);
        end
    end

    assign w_any = |w_nonempty;

    always_comb begin
        if (w_nonempty[Q_A]) begin
            w_pop_q = Q_A;
        end else if (w_nonempty[Q_B]) begin
            w_pop_q = Q_B;
        end else if (w_nonempty[Q_C]) begin
            w_pop_q = Q_C;
        end else begin
            w_pop_q = Q_D;
        end
    end

    assign w_q        = (i_op == OP_POP) ? w_pop_q : i_queue_sel;
    assign w_full     = (r_occ[w_q] == OCC_W'(QUEUE_DEPTH));
    assign w_ptr      = (i_op == OP_POP) ? r_head[w_q] : r_tail[w_q];
    assign w_ptr_next = (w_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(w_ptr + PTR_W'(1));
    assign w_base     = ADDR_W'(ADDR_W'(w_q) * ADDR_W'(QUEUE_DEPTH));
    assign o_addr     = ADDR_W'(w_base + ADDR_W'(w_ptr));

    always_comb begin
        w_cmd = '0;
        if (i_op == OP_POP) begin
            if (w_any) begin
                w_cmd.rd_en      = 1'b1;
                w_cmd.status     = ST_POP;
                w_cmd.qid        = w_q;
                w_cmd.job_number = JOBNUM_W'(r_pops[w_q] + JOBNUM_W'(1));
            end else begin
                w_cmd.status     = ST_EMPTY;
                w_cmd.qid        = Q_A;
            end
        end else begin
            w_cmd.wr_en  = !w_full;
            w_cmd.status = w_full ? ST_DROP : ST_ENQ;
            w_cmd.qid    = w_q;
        end
    end

    assign o_cmd = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_QUEUES; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_occ[k]  <= '0;
                r_pops[k] <= '0;
            end
        end else if (i_fire) begin
            if (w_cmd.wr_en) begin
                r_tail[w_q] <= w_ptr_next;
                r_occ[w_q]  <= OCC_W'(r_occ[w_q] + OCC_W'(1));
            end
            if (w_cmd.rd_en) begin
                r_head[w_q] <= w_ptr_next;
                r_occ[w_q]  <= OCC_W'(r_occ[w_q] - OCC_W'(1));
                r_pops[w_q] <= w_cmd.job_number;
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for four_class_job_fifo_core: four job queues with strict-priority pop.
// Keeps a shadow copy of the queues to predict every result; drives and samples at the clock edge.
// Depends on fcjf_pkg and the four_class_job_fifo_core RTL.
`timescale 1ns / 1ps

module tb;
    import fcjf_pkg::*;

    localparam int DEPTH        = DEF_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        t_status              status;
        logic [QID_W-1:0]     qid;
        logic [JOBNUM_W-1:0]  num;
        logic [JOB_OUT_W-1:0] job;
    } t_outcome;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_op        = OP_ENQ;
    logic [QID_W-1:0]     i_queue_sel = Q_A;
    logic [JOB_IN_W-1:0]  i_job_id    = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [1:0]           o_status;
    logic [QID_W-1:0]     o_queue_id;
    logic [JOBNUM_W-1:0]  o_job_number;
    logic [JOB_OUT_W-1:0] o_job_out;

    // shadow copy of the job queues
    bit [JOB_IN_W-1:0] shadow_store [NUM_QUEUES][DEPTH];
    int                shadow_head  [NUM_QUEUES];
    int                shadow_tail  [NUM_QUEUES];
    int                shadow_fill  [NUM_QUEUES];
    bit [JOBNUM_W-1:0] shadow_pops  [NUM_QUEUES];

    t_outcome pending_outcomes [$];

    int send_idle_pct = 26;
    int recv_idle_pct = 88;
    int cycle_count   = 0;
    int error_count   = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int enqs_seen     = 0;
    int drops_seen    = 0;
    int pops_seen     = 0;
    int empties_seen  = 0;

    four_class_job_fifo_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_queue_sel  (i_queue_sel),
        .i_job_id     (i_job_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_queue_id   (o_queue_id),
        .o_job_number (o_job_number),
        .o_job_out    (o_job_out)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic t_outcome dispatch_outcome(input logic op,
                                                  input logic [QID_W-1:0] q,
                                                  input logic [JOB_IN_W-1:0] id);
        t_outcome r;
        bit       taken;
        int       k;
        r.status = ST_EMPTY;
        r.qid    = Q_A;
        r.num    = '0;
        r.job    = '0;
        if (op == OP_ENQ) begin
            r.qid = q;
            if (shadow_fill[q] >= DEPTH) begin
                r.status = ST_DROP;
            end else begin
                shadow_store[q][shadow_tail[q]] = id;
                shadow_tail[q] = (shadow_tail[q] + 1) % DEPTH;
                shadow_fill[q]++;
                r.status = ST_ENQ;
            end
        end else begin
            taken = 1'b0;
            for (k = 0; k < NUM_QUEUES; k++) begin
                if (!taken && shadow_fill[k] != 0) begin
                    taken = 1'b1;
                    r.job = shadow_store[k][shadow_head[k]];
                    shadow_head[k] = (shadow_head[k] + 1) % DEPTH;
                    shadow_fill[k]--;
                    shadow_pops[k] = shadow_pops[k] + 1'b1;
                    r.status = ST_POP;
                    r.qid    = QID_W'(k);
                    r.num    = shadow_pops[k];
                end
            end
        end
        return r;
    endfunction

    function automatic bit any_queued();
        int k;
        int total;
        total = 0;
        for (k = 0; k < NUM_QUEUES; k++) total += shadow_fill[k];
        return total != 0;
    endfunction

    // hold the transaction until accepted, then record its outcome
    task automatic send_job(input logic op, input logic [QID_W-1:0] q,
                            input logic [JOB_IN_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_queue_sel <= q;
        i_job_id    <= id;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_outcomes.push_back(dispatch_outcome(op, q, id));
        sent_count++;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outcomes.size() == 0) begin
                if (error_count < 10)
                    $display("tb: unexpected result at %0t: status %0d queue %0d job %h",
                             $time, o_status, o_queue_id, o_job_out);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                checked_count++;
                case (want.status)
                    ST_ENQ:  enqs_seen++;
                    ST_DROP: drops_seen++;
                    ST_POP:  pops_seen++;
                    default: empties_seen++;
                endcase
                if (o_status !== want.status || o_queue_id !== want.qid ||
                    o_job_number !== want.num || o_job_out !== want.job) begin
                    if (error_count < 10)
                        $display("tb: mismatch at %0t: expected %0d/%0d/%0d/%h, got %0d/%0d/%0d/%h",
                                 $time, want.status, want.qid, want.num, want.job,
                                 o_status, o_queue_id, o_job_number, o_job_out);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_directed();
        send_job(OP_POP, Q_D, 32'hFFFF_FFFF);
        send_job(OP_ENQ, Q_D, 32'hFFFF_FFFF);
        send_job(OP_ENQ, Q_C, 32'h0000_0000);
        send_job(OP_ENQ, Q_B, 32'hAAAA_AAAA);
        send_job(OP_ENQ, Q_A, 32'h5555_5555);
        send_job(OP_ENQ, Q_D, 32'h1234_5678);
        send_job(OP_POP, Q_A, 32'h0000_0000);
        send_job(OP_POP, Q_B, 32'hFFFF_FFFF);
        send_job(OP_POP, Q_C, 32'h5555_5555);
        send_job(OP_POP, Q_D, 32'hAAAA_AAAA);
        send_job(OP_POP, Q_A, $urandom());
        send_job(OP_POP, Q_B, $urandom());
        send_job(OP_ENQ, Q_B, 32'h0000_0001);
        send_job(OP_ENQ, Q_A, 32'h8000_0000);
        send_job(OP_POP, Q_C, $urandom());
        send_job(OP_ENQ, Q_A, 32'h7FFF_FFFF);
        send_job(OP_POP, Q_D, $urandom());
        send_job(OP_POP, Q_A, $urandom());
        send_job(OP_POP, Q_B, $urandom());
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) begin
            if ($urandom_range(99) < 55)
                send_job(OP_ENQ, QID_W'($urandom_range(3)), $urandom());
            else
                send_job(OP_POP, QID_W'($urandom_range(3)), $urandom());
        end
    endtask

    // empty all queues, fill one queue past full, then drain everything so both pointers wrap
    task automatic test_fill_and_drain();
        logic [QID_W-1:0] q;
        while (any_queued()) send_job(OP_POP, QID_W'($urandom_range(3)), $urandom());
        q = QID_W'($urandom_range(3));
        while (shadow_fill[q] < DEPTH) send_job(OP_ENQ, q, $urandom());
        repeat ($urandom_range(2, 4)) send_job(OP_ENQ, q, $urandom());
        while (any_queued()) begin
            if ($urandom_range(99) < 5)
                send_job(OP_ENQ, QID_W'($urandom_range(3)), $urandom());
            else
                send_job(OP_POP, QID_W'($urandom_range(3)), $urandom());
        end
        send_job(OP_POP, QID_W'($urandom_range(3)), $urandom());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_mix(40);
        send_idle_pct = 88;
        recv_idle_pct = 26;
        test_fill_and_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(40);
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d transactions sent, %0d results checked, %0d mismatches",
                 sent_count, checked_count, error_count);
        $display("tb: %0d enqueued, %0d dropped on full, %0d popped, %0d pops on empty",
                 enqs_seen, drops_seen, pops_seen, empties_seen);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== four_class_job_fifo_core.f =====
+incdir+sv
sv/fcjf_pkg.sv
sv/fcjf_ram.sv
sv/fcjf_ctrl.sv
sv/four_class_job_fifo_core.sv
tb/sv/tb.sv
